// ===== rtl/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared widths, constants and types of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bpt_pkg;

	// Port widths
	localparam int RAW_W      = 24;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TEMP_OUT_W = 15;
	localparam int PRES_OUT_W = 17;

	// Internal widths (sized for the full range of inputs and coefficients)
	localparam int DT_W    = RAW_W + 1;        // D2 - C5*256
	localparam int PRODC_W = DT_W + COEF_W + 1; // dT * coefficient
	localparam int DTSQ_W  = 2 * DT_W;          // dT^2
	localparam int A_W     = PRODC_W - 23;      // TEMP - 2000
	localparam int TEMP_W  = A_W + 2;
	localparam int B_W     = A_W + 1;           // TEMP + 1500
	localparam int SQ_W    = 2 * A_W;
	localparam int SQ2_W   = 2 * B_W;
	localparam int T2_W    = 18;
	localparam int OFF_W   = 41;
	localparam int SENS_W  = 41;
	localparam int LO_W    = 20;                // low slice of SENS for the split multiply
	localparam int HI_W    = SENS_W - LO_W;
	localparam int PROD_W  = 64;
	localparam int X_W     = 45;
	localparam int P_W     = X_W - 15;

	// Scheme constants
	localparam int TEMP_REF     = 2000;
	localparam int TEMP_COLD    = -1500;
	localparam int TEMP_MIN     = -4000;
	localparam int TEMP_MAX     = 8500;
	localparam int PRES_MIN     = 1000;
	localparam int PRES_MAX     = 120000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS       = 3'd0,
		REG_OFFSET     = 3'd1,
		REG_SENS_TC    = 3'd2,
		REG_OFFSET_TC  = 3'd3,
		REG_REF_TEMP   = 3'd4,
		REG_TEMP_SLOPE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] offset;
		logic [COEF_W-1:0] sens_tc;
		logic [COEF_W-1:0] offset_tc;
		logic [COEF_W-1:0] ref_temp;
		logic [COEF_W-1:0] temp_slope;
	} coef_t;

endpackage

// ===== rtl/bpt_if.sv =====
// ----------------------------------------------------------------------------
// bpt channel interfaces
// Valid/ready channels for raw sample pairs and compensated results.
// ----------------------------------------------------------------------------
interface bpt_sample_if;
	import bpt_pkg::*;

	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] pressure_raw;
	logic [RAW_W-1:0] temperature_raw;

	modport source (output valid, output pressure_raw, output temperature_raw, input ready);
	modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bpt_result_if;
	import bpt_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [TEMP_OUT_W-1:0] temperature_centi;
	logic        [PRES_OUT_W-1:0] pressure_pa;
	logic                         clamped;

	modport source (output valid, output temperature_centi, output pressure_pa,
		output clamped, input ready);
	modport sink   (input valid, input temperature_centi, input pressure_pa,
		input clamped, output ready);
endinterface

// ===== rtl/bpt_wide_mul.sv =====
// ----------------------------------------------------------------------------
// bpt_wide_mul
// Two-stage D1 * SENS product, split into two partial products of SENS.
// ----------------------------------------------------------------------------
module bpt_wide_mul (
	input  logic                               clk,
	input  logic                               en_s7,
	input  logic                               en_s8,
	input  logic        [bpt_pkg::RAW_W-1:0]   d1,
	input  logic signed [bpt_pkg::SENS_W-1:0]  sens,
	output logic signed [bpt_pkg::PROD_W-1:0]  prod
);
	import bpt_pkg::*;

	logic        [RAW_W+LO_W-1:0]   lo_s7;
	logic signed [RAW_W+HI_W:0]     hi_s7;
	logic signed [PROD_W-1:0]       prod_s8;

	// stage 7: partial products, low slice unsigned, high slice signed
	always_ff @(posedge clk) begin
		if (en_s7) begin
			lo_s7 <= d1 * sens[LO_W-1:0];
			hi_s7 <= $signed({1'b0, d1}) * $signed(sens[SENS_W-1:LO_W]);
		end
	end

	// stage 8: recombine
	always_ff @(posedge clk) begin
		if (en_s8) begin
			prod_s8 <= PROD_W'($signed({hi_s7, {LO_W{1'b0}}}))
				+ PROD_W'($signed({1'b0, lo_s7}));
		end
	end

	assign prod = prod_s8;

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order temperature compensation of a barometric sensor, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   sample : sink channel, one transaction carries a raw pressure (D1) and
//            raw temperature (D2) conversion pair.
//   result : source channel, one transaction per sample with temperature in
//            0.01 degC, pressure in Pa and a flag set when either saturated.
//   cfg_*  : write port for the six calibration coefficients C1..C6
//            (index 0..5); other indexes are ignored. Write only while idle.
// Throughput is one transaction per cycle while the receiver keeps result.ready
// high: ten register stages, each with its own valid bit, the two wide product
// steps cut into partial products.
// Reset clears the valid bits and the coefficients (all zero); coefficients
// left at zero give saturated, flagged results.
// When the receiver stalls, each stage holds only if the stage after it is
// full and held, so bubbles get squeezed out and sample.ready drops only
// once every stage is occupied. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpt_pkg::COEF_W-1:0]        cfg_data,
	bpt_sample_if.sink                        sample,
	bpt_result_if.source                      result
);
	import bpt_pkg::*;

	localparam int STAGES = 10;

	coef_t coef_q;

	// ------------------------------------------------------------------
	// Coefficient registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SENS:       coef_q.sens       <= cfg_data;
				REG_OFFSET:     coef_q.offset     <= cfg_data;
				REG_SENS_TC:    coef_q.sens_tc    <= cfg_data;
				REG_OFFSET_TC:  coef_q.offset_tc  <= cfg_data;
				REG_REF_TEMP:   coef_q.ref_temp   <= cfg_data;
				REG_TEMP_SLOPE: coef_q.temp_slope <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage loads when it is empty or when the
	// stage after it is moving on.
	// ------------------------------------------------------------------
	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] en;

	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || result.ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = en[0];

	// ------------------------------------------------------------------
	// Stage 1: dT = D2 - C5*256
	// ------------------------------------------------------------------
	logic        [RAW_W-1:0] d1_s1;
	logic signed [DT_W-1:0]  dt_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1 <= sample.pressure_raw;
			dt_s1 <= $signed({1'b0, sample.temperature_raw})
				- $signed({1'b0, coef_q.ref_temp, 8'h00});
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: the four products of dT
	// ------------------------------------------------------------------
	logic        [RAW_W-1:0]   d1_s2;
	logic signed [PRODC_W-1:0] prod_t_s2;
	logic signed [PRODC_W-1:0] prod_o_s2;
	logic signed [PRODC_W-1:0] prod_s_s2;
	logic signed [DTSQ_W-1:0]  dtsq_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s2     <= d1_s1;
			prod_t_s2 <= dt_s1 * $signed({1'b0, coef_q.temp_slope});
			prod_o_s2 <= dt_s1 * $signed({1'b0, coef_q.offset_tc});
			prod_s_s2 <= dt_s1 * $signed({1'b0, coef_q.sens_tc});
			dtsq_s2   <= dt_s1 * dt_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: first-order TEMP, OFF, SENS and T2. The arithmetic shifts
	// floor toward minus infinity, as the integer scheme expects.
	// a = TEMP - 2000
	// ------------------------------------------------------------------
	logic        [RAW_W-1:0]  d1_s3;
	logic signed [A_W-1:0]    a_s3;
	logic signed [OFF_W-1:0]  off_s3;
	logic signed [SENS_W-1:0] sens_s3;
	logic        [T2_W-1:0]   t2_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d1_s3   <= d1_s2;
			a_s3    <= $signed(prod_t_s2[PRODC_W-1:23]);
			off_s3  <= $signed(OFF_W'({coef_q.offset, 16'h0000}))
				+ OFF_W'(prod_o_s2 >>> 7);
			sens_s3 <= $signed(SENS_W'({coef_q.sens, 15'h0000}))
				+ SENS_W'(prod_s_s2 >>> 8);
			t2_s3   <= dtsq_s2[T2_W+30:31];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: squares for the second-order terms
	// cold  : TEMP < 2000
	// vcold : TEMP < -1500
	// ------------------------------------------------------------------
	logic signed [B_W-1:0] b_c;

	assign b_c = $signed({a_s3[A_W-1], a_s3}) + B_W'(TEMP_REF - TEMP_COLD);

	logic        [RAW_W-1:0]  d1_s4;
	logic signed [TEMP_W-1:0] temp_s4;
	logic signed [OFF_W-1:0]  off_s4;
	logic signed [SENS_W-1:0] sens_s4;
	logic        [T2_W-1:0]   t2_s4;
	logic signed [SQ_W-1:0]   sq_s4;
	logic signed [SQ2_W-1:0]  sq2_s4;
	logic                     cold_s4;
	logic                     vcold_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			d1_s4    <= d1_s3;
			temp_s4  <= TEMP_W'(a_s3) + TEMP_W'(TEMP_REF);
			off_s4   <= off_s3;
			sens_s4  <= sens_s3;
			t2_s4    <= t2_s3;
			sq_s4    <= a_s3 * a_s3;
			sq2_s4   <= b_c * b_c;
			cold_s4  <= a_s3[A_W-1];
			vcold_s4 <= b_c[B_W-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: OFF2, SENS2 and the corrected TEMP. Constant multiplies by
	// 5, 7 and 11 are shift-and-add.
	// ------------------------------------------------------------------
	logic signed [OFF_W-1:0] sq_w;
	logic signed [OFF_W-1:0] sq2_w;
	logic signed [OFF_W-1:0] sq_x5;
	logic signed [OFF_W-1:0] sq2_x7;
	logic signed [OFF_W-1:0] sq2_x11;
	logic signed [OFF_W-1:0] off2_c;
	logic signed [OFF_W-1:0] sens2_c;

	always_comb begin
		sq_w    = OFF_W'(sq_s4);
		sq2_w   = OFF_W'(sq2_s4);
		sq_x5   = (sq_w <<< 2) + sq_w;
		sq2_x7  = (sq2_w <<< 3) - sq2_w;
		sq2_x11 = (sq2_w <<< 3) + (sq2_w <<< 1) + sq2_w;
		off2_c  = '0;
		sens2_c = '0;
		if (cold_s4) begin
			off2_c  = sq_x5 >>> 1;
			sens2_c = sq_x5 >>> 2;
			if (vcold_s4) begin
				off2_c  = off2_c + sq2_x7;
				sens2_c = sens2_c + (sq2_x11 >>> 1);
			end
		end
	end

	logic        [RAW_W-1:0]  d1_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	logic signed [OFF_W-1:0]  off_s5;
	logic signed [SENS_W-1:0] sens_s5;
	logic signed [OFF_W-1:0]  off2_s5;
	logic signed [SENS_W-1:0] sens2_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			d1_s5    <= d1_s4;
			temp_s5  <= cold_s4 ? temp_s4 - $signed(TEMP_W'(t2_s4)) : temp_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= SENS_W'(sens2_c);
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: final OFF and SENS; temperature saturation
	// ------------------------------------------------------------------
	logic signed [TEMP_OUT_W-1:0] temp_sat_c;
	logic                         temp_clip_c;

	always_comb begin
		temp_sat_c  = TEMP_OUT_W'(temp_s5);
		temp_clip_c = 1'b0;
		if (temp_s5 < TEMP_W'(TEMP_MIN)) begin
			temp_sat_c  = TEMP_OUT_W'(TEMP_MIN);
			temp_clip_c = 1'b1;
		end else if (temp_s5 > TEMP_W'(TEMP_MAX)) begin
			temp_sat_c  = TEMP_OUT_W'(TEMP_MAX);
			temp_clip_c = 1'b1;
		end
	end

	logic        [RAW_W-1:0]      d1_s6;
	logic signed [OFF_W-1:0]      off_s6;
	logic signed [SENS_W-1:0]     sens_s6;
	logic signed [TEMP_OUT_W-1:0] temp_s6;
	logic                         tclip_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			d1_s6    <= d1_s5;
			off_s6   <= off_s5 - off2_s5;
			sens_s6  <= sens_s5 - sens2_s5;
			temp_s6  <= temp_sat_c;
			tclip_s6 <= temp_clip_c;
		end
	end

	// ------------------------------------------------------------------
	// Stages 7-8: D1 * SENS in the split multiplier; side data follows
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0] prod_s8;

	bpt_wide_mul u_wide_mul (
		.clk   (clk),
		.en_s7 (en[6]),
		.en_s8 (en[7]),
		.d1    (d1_s6),
		.sens  (sens_s6),
		.prod  (prod_s8)
	);

	logic signed [OFF_W-1:0]      off_s7;
	logic signed [TEMP_OUT_W-1:0] temp_s7;
	logic                         tclip_s7;
	logic signed [OFF_W-1:0]      off_s8;
	logic signed [TEMP_OUT_W-1:0] temp_s8;
	logic                         tclip_s8;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			off_s7   <= off_s6;
			temp_s7  <= temp_s6;
			tclip_s7 <= tclip_s6;
		end
		if (en[7]) begin
			off_s8   <= off_s7;
			temp_s8  <= temp_s7;
			tclip_s8 <= tclip_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: asr(D1*SENS, 21) - OFF
	// ------------------------------------------------------------------
	logic signed [X_W-1:0]        x_s9;
	logic signed [TEMP_OUT_W-1:0] temp_s9;
	logic                         tclip_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			x_s9     <= X_W'(prod_s8 >>> 21) - X_W'(off_s8);
			temp_s9  <= temp_s8;
			tclip_s9 <= tclip_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: P = asr(x, 15), saturate, output register
	// ------------------------------------------------------------------
	logic signed [P_W-1:0]        p_c;
	logic        [PRES_OUT_W-1:0] pres_sat_c;
	logic                         pres_clip_c;

	always_comb begin
		p_c         = $signed(x_s9[X_W-1:15]);
		pres_sat_c  = PRES_OUT_W'(p_c);
		pres_clip_c = 1'b0;
		if (p_c < P_W'(PRES_MIN)) begin
			pres_sat_c  = PRES_OUT_W'(PRES_MIN);
			pres_clip_c = 1'b1;
		end else if (p_c > P_W'(PRES_MAX)) begin
			pres_sat_c  = PRES_OUT_W'(PRES_MAX);
			pres_clip_c = 1'b1;
		end
	end

	logic signed [TEMP_OUT_W-1:0] temp_s10;
	logic        [PRES_OUT_W-1:0] pres_s10;
	logic                         clip_s10;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			temp_s10 <= temp_s9;
			pres_s10 <= pres_sat_c;
			clip_s10 <= tclip_s9 | pres_clip_c;
		end
	end

	assign result.valid             = vld_q[STAGES-1];
	assign result.temperature_centi = temp_s10;
	assign result.pressure_pa       = pres_s10;
	assign result.clamped           = clip_s10;

endmodule
